// ----- src/bowq_pkg.sv -----
`default_nettype none
package bowq_pkg;
	localparam int MaxClusters = 64;
	localparam int DescDim = 128;
	localparam int ClW = 6;
	localparam int DimW = 7;
	localparam int AddrW = ClW + DimW;
	localparam int CntW = 16;
	localparam int DistW = 40;
	localparam logic [CntW-1:0] CountMax = '1;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_DESC = 2'd1,
		OP_EOI  = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [5:0]  cluster_index;
		logic [6:0]  dim_index;
		logic [15:0] centroid_value;
		logic [7:0]  descriptor_value;
	} in_word_t;

	typedef struct packed {
		logic [5:0]  bin_index;
		logic [15:0] bin_count;
		logic        last_bin;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DRAIN,
		ST_BUMP_RD,
		ST_BUMP_WR,
		ST_READOUT
	} state_t;

	// histogram port request
	typedef struct packed {
		logic            rd_en;
		logic [ClW-1:0]  rd_addr;
		logic            wr_en;
		logic [ClW-1:0]  wr_addr;
		logic [CntW-1:0] wr_data;
	} hist_req_t;
endpackage
`default_nettype wire

// ----- src/bowq_hist.sv -----
`default_nettype none
module bowq_hist (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               clear,
	input  wire bowq_pkg::hist_req_t req,
	output logic [bowq_pkg::CntW-1:0] rd_data
);
	logic [bowq_pkg::CntW-1:0] mem [bowq_pkg::MaxClusters];
	logic [bowq_pkg::MaxClusters-1:0] valid_q;
	logic [bowq_pkg::CntW-1:0] raw_q;
	logic vld_s1;

	// counter storage
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			raw_q <= mem[req.rd_addr];
		end
	end

	// valid bits make a cleared entry read zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (req.rd_en) begin
				vld_s1 <= valid_q[req.rd_addr];
			end
			if (clear) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = vld_s1 ? raw_q : '0;
endmodule
`default_nettype wire

// ----- src/bag_of_words_quantizer_top.sv -----
// channel   | ports                              | handshake
// ----------+------------------------------------+------------------------
// command   | start, busy, cmd (in_word_t)       | start && !busy
// result    | result_valid, result (out_word_t)  | strobe, one cycle
// config    | cfg_we, cfg_data                   | cfg_we
//
// a load or a descriptor word leaves the block idle, except the last word
// of a descriptor, which starts the search: one codebook read per cycle
// through a single multiply-accumulate, then a drain and the bin update.
// end of image runs the readout, one histogram read per bin. reset clears
// the histogram valid bits and the element position; the receiver cannot
// stall, results are never held.
`default_nettype none
module bag_of_words_quantizer_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire bowq_pkg::in_word_t cmd,
	output logic                    busy,
	input  wire logic               cfg_we,
	input  wire logic [6:0]         cfg_data,
	output logic                    result_valid,
	output bowq_pkg::out_word_t     result
);
	logic [6:0] active_q;
	logic [bowq_pkg::DimW-1:0] pos_q;
	bowq_pkg::state_t state_q, state_d;

	logic [15:0] codebook [bowq_pkg::MaxClusters*bowq_pkg::DescDim];
	logic [7:0] descbuf [bowq_pkg::DescDim];
	logic [15:0] cb_s1;
	logic [7:0] db_s1;

	logic [bowq_pkg::ClW-1:0] k_q;
	logic [bowq_pkg::DimW-1:0] d_q;
	logic rd_vld_s1, rd_last_s1;
	logic [bowq_pkg::ClW-1:0] rd_k_s1;
	logic [33:0] sq_s2;
	logic sq_vld_s2, sq_last_s2;
	logic [bowq_pkg::ClW-1:0] sq_k_s2;
	logic [bowq_pkg::DistW-1:0] acc_q, best_q;
	logic [bowq_pkg::ClW-1:0] best_k_q;
	logic best_set_q;
	logic [1:0] drain_q;
	logic [bowq_pkg::ClW-1:0] ro_q;
	logic ro_vld_s1, ro_last_s1;
	logic [bowq_pkg::ClW-1:0] ro_k_s1;

	logic accept;
	logic [bowq_pkg::ClW-1:0] nm1;
	logic hist_clear;
	bowq_pkg::hist_req_t hreq;
	logic [bowq_pkg::CntW-1:0] hrd;

	assign accept = start && !busy;
	assign busy = (state_q != bowq_pkg::ST_IDLE);

	// clamp active count to 1..64, keep it as n - 1
	always_comb begin
		if (active_q == 7'd0) begin
			nm1 = '0;
		end else if (active_q > 7'd64) begin
			nm1 = '1;
		end else begin
			nm1 = bowq_pkg::ClW'(active_q - 7'd1);
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 7'd64;
		end else if (cfg_we) begin
			active_q <= cfg_data;
		end
	end

	// codebook and descriptor buffer memories
	always_ff @(posedge clk) begin
		if (accept && cmd.opcode == bowq_pkg::OP_LOAD) begin
			codebook[{cmd.cluster_index, cmd.dim_index}] <= cmd.centroid_value;
		end
		if (accept && cmd.opcode == bowq_pkg::OP_DESC) begin
			descbuf[pos_q] <= cmd.descriptor_value;
		end
		cb_s1 <= codebook[{k_q, d_q}];
		db_s1 <= descbuf[d_q];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bowq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bowq_pkg::ST_IDLE: begin
				if (accept && cmd.opcode == bowq_pkg::OP_DESC && pos_q == '1) begin
					state_d = bowq_pkg::ST_SEARCH;
				end else if (accept && cmd.opcode == bowq_pkg::OP_EOI) begin
					state_d = bowq_pkg::ST_READOUT;
				end
			end
			bowq_pkg::ST_SEARCH: begin
				if (k_q == nm1 && d_q == '1) begin
					state_d = bowq_pkg::ST_DRAIN;
				end
			end
			bowq_pkg::ST_DRAIN: begin
				if (drain_q == 2'd2) begin
					state_d = bowq_pkg::ST_BUMP_RD;
				end
			end
			bowq_pkg::ST_BUMP_RD: state_d = bowq_pkg::ST_BUMP_WR;
			bowq_pkg::ST_BUMP_WR: state_d = bowq_pkg::ST_IDLE;
			bowq_pkg::ST_READOUT: begin
				if (ro_last_s1) begin
					state_d = bowq_pkg::ST_IDLE;
				end
			end
			default: state_d = bowq_pkg::ST_IDLE;
		endcase
	end

	// sequencing counters and the distance datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			k_q <= '0;
			d_q <= '0;
			rd_vld_s1 <= 1'b0;
			sq_vld_s2 <= 1'b0;
			drain_q <= '0;
			best_set_q <= 1'b0;
			ro_q <= '0;
			ro_vld_s1 <= 1'b0;
		end else begin
			if (accept && cmd.opcode == bowq_pkg::OP_DESC) begin
				pos_q <= pos_q + 1'b1;
			end else if (accept && cmd.opcode == bowq_pkg::OP_EOI) begin
				pos_q <= '0;
			end
			rd_vld_s1 <= (state_q == bowq_pkg::ST_SEARCH);
			sq_vld_s2 <= rd_vld_s1;
			if (state_q == bowq_pkg::ST_SEARCH) begin
				d_q <= d_q + 1'b1;
				if (d_q == '1) begin
					k_q <= k_q + 1'b1;
				end
			end else begin
				d_q <= '0;
				k_q <= '0;
			end
			drain_q <= (state_q == bowq_pkg::ST_DRAIN) ? drain_q + 2'd1 : 2'd0;
			if (state_q == bowq_pkg::ST_IDLE) begin
				best_set_q <= 1'b0;
			end else if (sq_vld_s2 && sq_last_s2) begin
				best_set_q <= 1'b1;
			end
			ro_vld_s1 <= (state_q == bowq_pkg::ST_READOUT) && !ro_last_s1 &&
				!(ro_vld_s1 && ro_k_s1 == nm1) && (ro_q <= nm1);
			if (state_q == bowq_pkg::ST_READOUT) begin
				ro_q <= ro_q + 1'b1;
			end else begin
				ro_q <= '0;
			end
		end
	end

	// payload pipeline: square, then accumulate and compare
	always_ff @(posedge clk) begin
		rd_k_s1 <= k_q;
		rd_last_s1 <= (d_q == '1);
		sq_k_s2 <= rd_k_s1;
		sq_last_s2 <= rd_last_s1;
		sq_s2 <= 34'($signed({1'b0, db_s1, 8'd0}) - $signed({1'b0, cb_s1})) *
			34'($signed({1'b0, db_s1, 8'd0}) - $signed({1'b0, cb_s1}));
		if (sq_vld_s2) begin
			if (sq_last_s2) begin
				acc_q <= '0;
				if (!best_set_q || (acc_q + 40'(sq_s2)) < best_q) begin
					best_q <= acc_q + 40'(sq_s2);
					best_k_q <= sq_k_s2;
				end
			end else begin
				acc_q <= acc_q + 40'(sq_s2);
			end
		end else if (state_q == bowq_pkg::ST_IDLE) begin
			acc_q <= '0;
		end
		ro_k_s1 <= ro_q;
		ro_last_s1 <= (state_q == bowq_pkg::ST_READOUT) && (ro_q == nm1);
	end

	// histogram accesses
	always_comb begin
		hreq = '0;
		if (state_q == bowq_pkg::ST_BUMP_RD) begin
			hreq.rd_en = 1'b1;
			hreq.rd_addr = best_k_q;
		end else if (state_q == bowq_pkg::ST_READOUT) begin
			hreq.rd_en = 1'b1;
			hreq.rd_addr = ro_q;
		end
		if (state_q == bowq_pkg::ST_BUMP_WR) begin
			hreq.wr_en = 1'b1;
			hreq.wr_addr = best_k_q;
			hreq.wr_data = (hrd == bowq_pkg::CountMax) ? hrd : hrd + 1'b1;
		end
	end
	assign hist_clear = (state_q == bowq_pkg::ST_READOUT) && ro_last_s1;

	bowq_hist u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (hist_clear),
		.req     (hreq),
		.rd_data (hrd)
	);

	// result word
	assign result_valid = (state_q == bowq_pkg::ST_READOUT) && ro_vld_s1;
	always_comb begin
		result.bin_index = ro_k_s1;
		result.bin_count = hrd;
		result.last_bin = ro_last_s1;
	end

	a_res_only_readout: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> state_q == bowq_pkg::ST_READOUT)
		else $error("result outside readout");
	a_bump_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bowq_pkg::ST_BUMP_WR |-> $past(state_q) == bowq_pkg::ST_BUMP_RD)
		else $error("bump write without read");
	a_busy_search: assert property (@(posedge clk) disable iff (!arst_n)
		sq_vld_s2 |-> busy)
		else $error("search data while idle");
endmodule
`default_nettype wire
